[design/tcp_congestion_window_control_defines.svh]
// Assertion macros shared by the congestion window control RTL.
// Define NO_ASSERTIONS to compile every check out.
`ifndef TCP_CONGESTION_WINDOW_CONTROL_DEFINES_SVH
`define TCP_CONGESTION_WINDOW_CONTROL_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle check, reset masks it.
`define TCWC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Condition now implies result at the next edge.
`define TCWC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define TCWC_ASSERT(lbl, prop, msg)
`define TCWC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

[design/tcwc_pkg.sv]
// Package for the congestion window control block: widths, reset values,
// event and register codes, sequencer state and divider status types.
`timescale 1ns / 1ps

package tcwc_pkg;

    localparam int MSS_W   = 16;
    localparam int WS_W    = 4;
    localparam int SEGS_W  = 16;
    localparam int SEQ_W   = 32;
    localparam int WIN_W   = 32;
    localparam int PEER_W  = 30;
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_W   = 32;
    localparam int PROD_W  = WIN_W + MSS_W;

    localparam logic [MSS_W-1:0]  MSS_RESET         = MSS_W'(536);
    localparam logic [WS_W-1:0]   WS_RESET          = '0;
    localparam logic [SEGS_W-1:0] RESTART_REMOTE_RST = SEGS_W'(1);
    localparam logic [SEGS_W-1:0] RESTART_LOCAL_RST  = SEGS_W'(4);
    localparam logic [WIN_W-1:0]  CWND_RESET        = '0;
    localparam logic [WIN_W-1:0]  THRESH_RESET      = WIN_W'(1073725440);
    localparam logic [WIN_W-1:0]  WIN_BASE          = WIN_W'(65535);
    localparam logic [WIN_W-1:0]  MIN_THRESH_SEGS   = WIN_W'(2);
    localparam logic [WIN_W-1:0]  MIN_CA_INCR       = WIN_W'(1);

    // event codes
    localparam logic [MODE_W-1:0] MODE_ACK       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ENTER_REC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LEAVE_REC = 3'd2;
    localparam logic [MODE_W-1:0] MODE_IDLE_RST  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TIMEOUT   = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MSS            = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WSCALE         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_REMOTE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_LOCAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_LOCAL     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

[design/tcwc_div.sv]
// Restoring divider, one quotient bit per cycle, for the window control block.
// Depends on tcwc_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "tcp_congestion_window_control_defines.svh"

module tcwc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tcwc_pkg::DIV_W-1:0] i_dividend,
    input  logic [tcwc_pkg::DIV_W-1:0] i_divisor,
    output tcwc_pkg::t_div_status      o_status,
    output logic [tcwc_pkg::DIV_W-1:0] o_quotient
);
    import tcwc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dvsr;

    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W-1:0] n_quo;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_W-1]};
        diff   = rem_sh - {1'b0, r_dvsr};
        ge     = ~diff[DIV_W];
        n_rem  = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        n_quo  = {r_quo[DIV_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

    `TCWC_ASSERT(a_done_not_busy, r_done |-> !r_busy, "divider done while still busy")
    `TCWC_ASSERT_NEXT(a_start_busy, i_start, r_busy && !r_done, "divider did not start")
    `TCWC_ASSERT_NEXT(a_last_step, r_busy && !i_start && r_cnt == '0, r_done && !r_busy,
        "divider missed its last step")
endmodule

[design/tcp_congestion_window_control.sv]
// Top level of the congestion window control block: sequencer, state, config.
// Depends on tcwc_pkg, tcwc_div and the shared assertion macros.
//
//  channel   signals                                   direction
//  in        i_in_valid / o_in_ready, event fields     into block
//  out       o_out_valid / i_out_ready, cwnd, ssthresh out of block
//  cfg       i_cfg_we, i_cfg_index, i_cfg_data         into block, write only
//
// Ack in slow start, leave recovery and unused codes go straight to the result.
// Idle restart: one shared multiply. Ack in congestion avoidance: multiply, then
// divide. Enter recovery / timeout: divide, then multiply (shared 32-step divider).
// Reset is synchronous: cwnd 0, ssthresh 1073725440, registers to defaults.
// A new item is taken only in idle; it is taken while an earlier result waits.
// A result that finds the output register full holds the sequencer until taken.
`timescale 1ns / 1ps
`include "tcp_congestion_window_control_defines.svh"

module tcp_congestion_window_control (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [tcwc_pkg::MODE_W-1:0]     i_mode,
    input  logic [tcwc_pkg::SEQ_W-1:0]      i_ack_number,
    input  logic                            i_has_ack_header,
    input  logic [tcwc_pkg::SEQ_W-1:0]      i_highest_sent,
    input  logic [tcwc_pkg::PEER_W-1:0]     i_peer_window,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tcwc_pkg::WIN_W-1:0]      o_congestion_window,
    output logic [tcwc_pkg::WIN_W-1:0]      o_slow_start_threshold,
    input  logic                            i_cfg_we,
    input  logic [tcwc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcwc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tcwc_pkg::*;

    // configuration
    logic [MSS_W-1:0]  r_mss;
    logic [WS_W-1:0]   r_wscale;
    logic [SEGS_W-1:0] r_rs_remote;
    logic [SEGS_W-1:0] r_rs_local;
    logic              r_peer_local;

    // connection state and latched item
    logic [WIN_W-1:0]  r_cwnd;
    logic [WIN_W-1:0]  r_thr;
    logic [MODE_W-1:0] r_mode;
    logic [SEQ_W-1:0]  r_ack;
    logic              r_has_ack;
    logic [SEQ_W-1:0]  r_snd;
    logic [PEER_W-1:0] r_pw;
    logic [PROD_W-1:0] r_prod;

    logic              r_out_valid;
    logic [WIN_W-1:0]  r_out_cwnd;
    logic [WIN_W-1:0]  r_out_thr;

    t_state r_state;
    t_state n_state;

    logic              accept;
    logic              mul_en;
    logic              div_start;
    logic              commit;
    logic [DIV_W-1:0]  div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic [DIV_W-1:0]  div_quo;
    t_div_status       div_stat;

    logic [WIN_W-1:0]  mul_a;
    logic [WIN_W-1:0]  base;
    logic [WIN_W-1:0]  seg_cnt;
    logic [WIN_W-1:0]  incr;
    logic [WIN_W:0]    sum;
    logic [WIN_W:0]    cap;
    logic [SEQ_W-1:0]  seq_d;
    logic              seq_after;
    logic [WIN_W-1:0]  n_cwnd;
    logic [WIN_W-1:0]  n_thr;

    assign accept = i_in_valid && o_in_ready;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mss        <= MSS_RESET;
            r_wscale     <= WS_RESET;
            r_rs_remote  <= RESTART_REMOTE_RST;
            r_rs_local   <= RESTART_LOCAL_RST;
            r_peer_local <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MSS:            r_mss        <= i_cfg_data[MSS_W-1:0];
                CFG_WSCALE:         r_wscale     <= i_cfg_data[WS_W-1:0];
                CFG_RESTART_REMOTE: r_rs_remote  <= i_cfg_data[SEGS_W-1:0];
                CFG_RESTART_LOCAL:  r_rs_local   <= i_cfg_data[SEGS_W-1:0];
                CFG_PEER_LOCAL:     r_peer_local <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_mode == MODE_ACK) begin
                        n_state = (r_cwnd > r_thr) ? ST_MUL : ST_DONE;
                    end else if (i_mode == MODE_ENTER_REC || i_mode == MODE_TIMEOUT) begin
                        n_state = (r_mss == '0) ? ST_DONE : ST_DIV_GO;
                    end else if (i_mode == MODE_IDLE_RST) begin
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MUL:      n_state = (r_mode == MODE_ACK) ? ST_DIV_GO : ST_DONE;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    n_state = (r_mode == MODE_ACK) ? ST_DONE : ST_MUL;
                end
            end
            ST_DONE:     n_state = commit ? ST_IDLE : ST_DONE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        mul_en     = (r_state == ST_MUL);
        div_start  = (r_state == ST_DIV_GO);
        commit     = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- shared multiplier and divider ----------------
    always_comb begin
        base    = ({2'b0, r_pw} < r_cwnd) ? {2'b0, r_pw} : r_cwnd;
        seg_cnt = (div_quo < MIN_THRESH_SEGS) ? MIN_THRESH_SEGS : div_quo;
        unique case (r_mode)
            MODE_ACK:      mul_a = {{(WIN_W-MSS_W){1'b0}}, r_mss};
            MODE_IDLE_RST: mul_a = {{(WIN_W-SEGS_W){1'b0}},
                                    r_peer_local ? r_rs_local : r_rs_remote};
            default:       mul_a = seg_cnt;
        endcase
        if (r_mode == MODE_ACK) begin
            div_dividend = r_prod[DIV_W-1:0];
            div_divisor  = r_cwnd;
        end else begin
            div_dividend = {1'b0, base[WIN_W-1:1]};
            div_divisor  = {{(DIV_W-MSS_W){1'b0}}, r_mss};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * r_mss;
        end
    end

    tcwc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_status   (div_stat),
        .o_quotient (div_quo)
    );

    // ---------------- item latch ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode    <= i_mode;
            r_ack     <= i_ack_number;
            r_has_ack <= i_has_ack_header;
            r_snd     <= i_highest_sent;
            r_pw      <= i_peer_window;
        end
    end

    // ---------------- final update ----------------
    always_comb begin
        incr = (r_cwnd > r_thr) ? ((div_quo < MIN_CA_INCR) ? MIN_CA_INCR : div_quo)
                                : {{(WIN_W-MSS_W){1'b0}}, r_mss};
        sum  = {1'b0, r_cwnd} + {1'b0, incr};
        cap  = {1'b0, WIN_BASE} << r_wscale;
        // sequence compare modulo 2^32: difference nonzero and positive
        seq_d     = r_ack + r_thr - r_snd;
        seq_after = (seq_d != '0) && !seq_d[SEQ_W-1];
        n_cwnd = r_cwnd;
        n_thr  = r_thr;
        unique case (r_mode)
            MODE_ACK:       n_cwnd = (sum < cap) ? sum[WIN_W-1:0] : cap[WIN_W-1:0];
            MODE_ENTER_REC: n_thr  = (r_mss == '0) ? '0 : r_prod[WIN_W-1:0];
            MODE_LEAVE_REC: n_cwnd = (r_has_ack && seq_after)
                                   ? r_snd - r_ack + {{(WIN_W-MSS_W){1'b0}}, r_mss}
                                   : r_thr;
            MODE_IDLE_RST:  n_cwnd = r_prod[WIN_W-1:0];
            MODE_TIMEOUT: begin
                n_thr  = (r_mss == '0) ? '0 : r_prod[WIN_W-1:0];
                n_cwnd = {{(WIN_W-MSS_W){1'b0}}, r_mss};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwnd <= CWND_RESET;
            r_thr  <= THRESH_RESET;
        end else if (commit) begin
            r_cwnd <= n_cwnd;
            r_thr  <= n_thr;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_cwnd <= n_cwnd;
            r_out_thr  <= n_thr;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_congestion_window    = r_out_cwnd;
    assign o_slow_start_threshold = r_out_thr;

    `TCWC_ASSERT(a_ready_div_idle, o_in_ready |-> !div_stat.busy,
        "input ready while divider runs")
    `TCWC_ASSERT(a_start_div_idle, div_start |-> !div_stat.busy,
        "divider started while busy")
    `TCWC_ASSERT(a_done_in_wait, div_stat.done |-> r_state == ST_DIV_WAIT,
        "divider finished outside its wait state")
    `TCWC_ASSERT_NEXT(a_commit_out, commit, r_out_valid && r_state == ST_IDLE,
        "committed item not presented at output")
endmodule
